### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hw/rtl/wcc_pkg.sv
// Types, constants and helpers of the windowed cross-correlator.
`default_nettype none
package wcc_pkg;
    localparam int WINDOW_DEPTH = 128;
    localparam int SAMPLE_W     = 16;
    localparam int LAG_W        = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = LAG_W + 1;
    localparam int SUM_W        = SAMPLE_W + LAG_W;
    localparam int PROD_W       = 2 * SUM_W;
    localparam int ACC_W        = 64;
    localparam int PASS_W       = 32;
    localparam int CFG_W        = 8;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(100);

    typedef enum logic {CMD_PUSH = 1'b0, CMD_READ = 1'b1} cmd_t;

    // one history entry: main and species sample, three axes each
    typedef struct packed {
        logic [2:0][SAMPLE_W-1:0] m;
        logic [2:0][SAMPLE_W-1:0] s;
    } sample_pair_t;

    // running sums handed from cell to cell during a pass
    typedef struct packed {
        logic                  v;
        logic [2:0][SUM_W-1:0] sm;
        logic [2:0][SUM_W-1:0] ss;
    } token_t;

    typedef logic [2:0][ACC_W-1:0] acc_vec_t;

    // saturating signed add at the 64-bit limits
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction
endpackage
`default_nettype wire

### hw/rtl/wcc_cell.sv
// One lag cell: history entry, running-sum stage, product stage, accumulators.
`default_nettype none
module wcc_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift_en,
    input  wire logic                  active,
    input  wire wcc_pkg::sample_pair_t sample_in,
    output wcc_pkg::sample_pair_t      sample_out,
    input  wire wcc_pkg::token_t       tok_in,
    output wcc_pkg::token_t            tok_out,
    output wcc_pkg::acc_vec_t          acc
);
    wcc_pkg::sample_pair_t                   samp_reg;
    wcc_pkg::token_t                         tok_reg, tok_next;
    logic                                    prod_v_reg;
    logic [2:0][wcc_pkg::PROD_W-1:0]         prod_reg, prod_next;
    wcc_pkg::acc_vec_t                       acc_reg, acc_next;

    // add own entry to the incoming sums, multiply, accumulate
    always_comb
    begin
        tok_next.v = tok_in.v && active;
        for (int a = 0; a < 3; a++)
        begin
            tok_next.sm[a] = wcc_pkg::SUM_W'($signed(tok_in.sm[a])
                             + $signed(samp_reg.m[a]));
            tok_next.ss[a] = wcc_pkg::SUM_W'($signed(tok_in.ss[a])
                             + $signed(samp_reg.s[a]));
            prod_next[a]   = wcc_pkg::PROD_W'($signed(tok_reg.sm[a]))
                             * wcc_pkg::PROD_W'($signed(tok_reg.ss[a]));
            acc_next[a]    = prod_v_reg
                ? wcc_pkg::sat_add(acc_reg[a],
                      wcc_pkg::ACC_W'($signed(prod_reg[a])))
                : acc_reg[a];
        end
    end

    // history shift and product register, no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
            samp_reg <= sample_in;
        prod_reg <= prod_next;
    end

    // control, running sums and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            tok_reg    <= tok_next;
            prod_v_reg <= tok_reg.v;
            acc_reg    <= acc_next;
        end
    end

    assign sample_out = samp_reg;
    assign tok_out    = tok_reg;
    assign acc        = acc_reg;
endmodule
`default_nettype wire

### hw/rtl/windowed_cross_correlator.sv
// Top level of the windowed cross-correlator: cell chain, control, read port.
// A push enters the history chain at acceptance; once the window is full it
// also starts a pass that runs down the row of lag cells one cell per cycle, so
// the block stays busy until the pass has run through the effective window
// and takes no item meanwhile. A read returns its beat in the cycle after
// acceptance from an output register. window_length reads 0 as 1 and clamps at
// the 128 cells.
`default_nettype none
`include "assert_macros.svh"
module windowed_cross_correlator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [wcc_pkg::CFG_W-1:0]            window_length,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 command,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  main_x,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  main_y,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  main_z,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  species_x,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  species_y,
    input  wire logic signed [wcc_pkg::SAMPLE_W-1:0]  species_z,
    input  wire logic [wcc_pkg::LAG_W-1:0]            read_lag,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [wcc_pkg::ACC_W-1:0]          acc_x,
    output logic signed [wcc_pkg::ACC_W-1:0]          acc_y,
    output logic signed [wcc_pkg::ACC_W-1:0]          acc_z,
    output logic [wcc_pkg::PASS_W-1:0]                passes_done,
    output logic                                      window_full
);
    localparam int D = wcc_pkg::WINDOW_DEPTH;

    logic [wcc_pkg::CFG_W-1:0]  wlen_reg;
    logic [wcc_pkg::LEN_W-1:0]  len_eff;
    logic [wcc_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [wcc_pkg::LEN_W-1:0]  cnt_reg;
    logic [wcc_pkg::PASS_W-1:0] pass_reg;
    logic                       busy_reg, go_reg;
    logic                       out_v_reg;
    wcc_pkg::acc_vec_t          out_acc_reg;
    logic [wcc_pkg::PASS_W-1:0] out_pass_reg;
    logic                       out_full_reg;
    logic                       accept, push, rd;

    wcc_pkg::sample_pair_t      samp_chain [D+1];
    wcc_pkg::token_t            tok_chain  [D+1];
    wcc_pkg::acc_vec_t          acc_all    [D];

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg && (!out_v_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign push      = accept && (command == wcc_pkg::CMD_PUSH);
    assign rd        = accept && (command == wcc_pkg::CMD_READ);

    // effective window and fill level after a push
    always_comb
    begin
        if (wlen_reg == '0)
            len_eff = wcc_pkg::LEN_W'(1);
        else if (32'(wlen_reg) > D)
            len_eff = wcc_pkg::LEN_W'(D);
        else
            len_eff = wcc_pkg::LEN_W'(wlen_reg);
        fill_next = (32'(fill_reg) < D) ? fill_reg + 1'b1 : fill_reg;
    end

    // new sample enters cell 0, pass starts with zero sums
    assign samp_chain[0] = '{m: {main_z, main_y, main_x},
                             s: {species_z, species_y, species_x}};
    assign tok_chain[0]  = '{v: go_reg, sm: '0, ss: '0};

    for (genvar k = 0; k < D; k++)
    begin : g_cell
        wcc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (push),
            .active     (k < 32'(len_eff)),
            .sample_in  (samp_chain[k]),
            .sample_out (samp_chain[k+1]),
            .tok_in     (tok_chain[k]),
            .tok_out    (tok_chain[k+1]),
            .acc        (acc_all[k])
        );
    end

    // control: config, fill, pass sequencing, read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= wcc_pkg::WINDOW_RESET;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            busy_reg  <= 1'b0;
            go_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                wlen_reg <= window_length;
            go_reg <= 1'b0;
            if (push)
            begin
                fill_reg <= fill_next;
                if (fill_next >= len_eff)
                begin
                    go_reg   <= 1'b1;
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    if (pass_reg != '1)
                        pass_reg <= pass_reg + 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == len_eff + 1'b1)
                    busy_reg <= 1'b0;
            end
            if (rd)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    // read payload
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            out_acc_reg  <= acc_all[read_lag[wcc_pkg::LAG_W-1:0]];
            out_pass_reg <= pass_reg;
            out_full_reg <= (fill_reg >= len_eff);
        end
    end

    assign out_valid   = out_v_reg;
    assign acc_x       = out_acc_reg[0];
    assign acc_y       = out_acc_reg[1];
    assign acc_z       = out_acc_reg[2];
    assign passes_done = out_pass_reg;
    assign window_full = out_full_reg;

    `ASSERT_PROP(a_go_busy, clk, rst_n, go_reg |-> busy_reg)
    `ASSERT_PROP(a_pass_mono, clk, rst_n, $past(pass_reg) <= pass_reg)
    `ASSERT_NEVER(a_fill_range, clk, rst_n, 32'(fill_reg) > D)
endmodule
`default_nettype wire

### test/tb_windowed_cross_correlator.sv
// Testbench for the windowed cross-correlator: directed and random pushes and reads against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_windowed_cross_correlator;
    localparam int DEPTH = wcc_pkg::WINDOW_DEPTH;

    typedef struct {
        wcc_pkg::cmd_t      cmd;
        logic signed [15:0] mx, my, mz, sx, sy, sz;
        logic [6:0]         lag;
    } cmd_beat_t;

    typedef struct {
        logic signed [63:0] ax, ay, az;
        logic [31:0]        passes;
        logic               full;
    } lag_read_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] window_length = 8'd100;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic signed [15:0] main_x = '0, main_y = '0, main_z = '0;
    logic signed [15:0] species_x = '0, species_y = '0, species_z = '0;
    logic [6:0] read_lag = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [63:0] acc_x, acc_y, acc_z;
    logic [31:0] passes_done;
    logic window_full;

    windowed_cross_correlator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .main_x(main_x), .main_y(main_y), .main_z(main_z),
        .species_x(species_x), .species_y(species_y), .species_z(species_z),
        .read_lag(read_lag),
        .out_valid(out_valid), .out_ready(out_ready),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .passes_done(passes_done), .window_full(window_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] hist_m [DEPTH][3];
    logic signed [15:0] hist_s [DEPTH][3];
    logic signed [63:0] lag_acc [DEPTH][3];
    int unsigned        head_slot;
    int unsigned        fill;
    logic [31:0]        pass_cnt;
    logic [7:0]         win_reg;

    cmd_beat_t pending_beats[$];
    lag_read_t expected_reads[$];
    int  fail_count = 0;
    bit  in_acc = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  sender_pause = 1'b0;

    function automatic int unsigned eff_len();
        if (win_reg == 0)
            return 1;
        if (win_reg > DEPTH)
            return DEPTH;
        return win_reg;
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // sums fit in 23 bits, so the product never saturates
    task automatic predict_beat(input cmd_beat_t b);
        int unsigned len, slot;
        logic signed [31:0] sm [3];
        logic signed [31:0] ss [3];
        lag_read_t r;
        len = eff_len();
        if (b.cmd == wcc_pkg::CMD_PUSH)
        begin
            head_slot = (head_slot + 1) % DEPTH;
            hist_m[head_slot] = '{b.mx, b.my, b.mz};
            hist_s[head_slot] = '{b.sx, b.sy, b.sz};
            if (fill < DEPTH)
                fill++;
            if (fill >= len)
            begin
                if (pass_cnt != 32'hFFFF_FFFF)
                    pass_cnt++;
                sm = '{0, 0, 0};
                ss = '{0, 0, 0};
                for (int k = 0; k < len; k++)
                begin
                    slot = (head_slot + DEPTH - k) % DEPTH;
                    for (int a = 0; a < 3; a++)
                    begin
                        sm[a] += hist_m[slot][a];
                        ss[a] += hist_s[slot][a];
                        lag_acc[k][a] = add_sat(lag_acc[k][a],
                                                64'(sm[a]) * 64'(ss[a]));
                    end
                end
            end
        end
        else
        begin
            r.ax = lag_acc[b.lag][0];
            r.ay = lag_acc[b.lag][1];
            r.az = lag_acc[b.lag][2];
            r.passes = pass_cnt;
            r.full = (fill >= len);
            expected_reads.push_back(r);
        end
    endtask

    // driver: bursts with random gaps; a beat stays until an edge accepts it
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_acc)
            begin
                // hold current beat
            end
            else if (pending_beats.size() != 0 && !sender_pause && gap_left == 0)
            begin
                cmd_beat_t b;
                b = pending_beats.pop_front();
                command <= b.cmd;
                main_x <= b.mx; main_y <= b.my; main_z <= b.mz;
                species_x <= b.sx; species_y <= b.sy; species_z <= b.sz;
                read_lag <= b.lag;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    int stall_phase = 0;
    int hold_cnt = 0;
    always @(negedge clk)
    begin
        stall_phase = (stall_phase + 1) % 23;
        if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 400)
                hold_done = 1'b1;
        end
        else if (stall_phase < 8)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // accepted inputs feed the predictor; accepted results are checked
    always @(posedge clk)
    begin
        in_acc = rst_n && in_valid && in_ready;
        if (in_acc)
            predict_beat(cmd_beat_t'{wcc_pkg::cmd_t'(command), main_x, main_y, main_z,
                                     species_x, species_y, species_z, read_lag});
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("unexpected result beat");
                fail_count++;
            end
            else
            begin
                lag_read_t e;
                e = expected_reads.pop_front();
                if (acc_x !== e.ax)
                begin
                    $error("acc_x exp %0d got %0d", e.ax, acc_x); fail_count++;
                end
                if (acc_y !== e.ay)
                begin
                    $error("acc_y exp %0d got %0d", e.ay, acc_y); fail_count++;
                end
                if (acc_z !== e.az)
                begin
                    $error("acc_z exp %0d got %0d", e.az, acc_z); fail_count++;
                end
                if (passes_done !== e.passes)
                begin
                    $error("passes_done exp %0d got %0d", e.passes, passes_done);
                    fail_count++;
                end
                if (window_full !== e.full)
                begin
                    $error("window_full exp %0d got %0d", e.full, window_full);
                    fail_count++;
                end
            end
        end
    end

    function automatic cmd_beat_t rand_push(int mode);
        cmd_beat_t b;
        logic signed [15:0] v [6];
        for (int i = 0; i < 6; i++)
        begin
            case (mode)
                1: v[i] = 16'sh7FFF;
                2: v[i] = 16'sh8000;
                3: v[i] = 16'(signed'($urandom_range(0, 1023)) - 512);
                default: v[i] = 16'($urandom);
            endcase
        end
        b = '{wcc_pkg::CMD_PUSH, v[0], v[1], v[2], v[3], v[4], v[5], 7'($urandom)};
        return b;
    endfunction

    function automatic cmd_beat_t rand_read(int lag_max);
        cmd_beat_t b;
        b = '{wcc_pkg::CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom),
              7'($urandom_range(0, lag_max))};
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_reads.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_window(input logic [7:0] len);
        @(negedge clk);
        window_length <= len;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        win_reg = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] win_set [6];
        head_slot = 0; fill = 0; pass_cnt = '0; win_reg = 8'd100;
        for (int i = 0; i < DEPTH; i++)
            for (int a = 0; a < 3; a++)
            begin
                hist_m[i][a] = '0; hist_s[i][a] = '0; lag_acc[i][a] = '0;
            end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reads before fill, short window, extremes
        pending_beats.push_back(rand_read(127));
        pending_beats.push_back('{wcc_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 7'd127});
        wait_drained();
        write_window(8'd0);
        pending_beats.push_back(rand_push(1));
        pending_beats.push_back(rand_push(2));
        pending_beats.push_back(rand_push(0));
        pending_beats.push_back('{wcc_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 7'd0});
        pending_beats.push_back('{wcc_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 7'd1});
        wait_drained();
        write_window(8'd4);
        for (int i = 0; i < 5; i++)
            pending_beats.push_back(rand_push(i % 2 + 1));
        for (int l = 0; l < 6; l++)
            pending_beats.push_back('{wcc_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 7'(l)});
        wait_drained();

        // random phases over several window settings, extremes among them
        win_set = '{8'd255, 8'd128, 8'd3, 8'd1, 8'd17, 8'd100};
        for (int p = 0; p < 6; p++)
        begin
            int n, lag_max;
            write_window(win_set[p]);
            n = (win_set[p] >= 100) ? 140 : 205;
            lag_max = (win_set[p] > 127) ? 127 : win_set[p] + 2;
            if (lag_max > 127) lag_max = 127;
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    pending_beats.push_back(
                        rand_read($urandom_range(0, 3) == 0 ? 127 : lag_max));
                else
                    pending_beats.push_back(
                        rand_push($urandom_range(0, 9) == 0 ? $urandom_range(1, 2)
                                  : ($urandom_range(0, 1) ? 3 : 0)));
            end
            if (p == 3)
            begin
                // long receiver hold-off while reads keep coming
                while (pending_beats.size() > n / 2)
                    @(posedge clk);
                hold_req = 1'b1;
                wait (hold_done);
                hold_req = 1'b0;
            end
            if (p == 2)
            begin
                // sender pauses until all results are in
                while (pending_beats.size() > n / 2)
                    @(posedge clk);
                sender_pause = 1'b1;
                while (in_valid || expected_reads.size() != 0)
                    @(posedge clk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

### windowed_cross_correlator.f
+incdir+hw/rtl
hw/rtl/wcc_pkg.sv
hw/rtl/wcc_cell.sv
hw/rtl/windowed_cross_correlator.sv
test/tb_windowed_cross_correlator.sv
